// ----- sv/circular_deque_macros.svh -----
// Assertion macros used by the deque checker.
`ifndef CIRCULAR_DEQUE_MACROS_SVH
`define CIRCULAR_DEQUE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define CDQ_ASSERT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("circular_deque check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define CDQ_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("circular_deque check failed");

`endif

// ----- sv/cdq_pkg.sv -----
// Shared types, constants and index helpers for the circular deque.
package cdq_pkg;

	localparam int DEPTH  = 8;
	localparam int DATA_W = 32;
	localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);

	localparam logic [CNT_W-1:0] OCC_FULL = CNT_W'(DEPTH);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);

	typedef enum logic [2:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_REAR  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_REAR   = 3'd3,
		OP_LIST       = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_LIST = 2'b10
	} state_t;

	typedef struct packed {
		logic                     we;
		logic [IDX_W-1:0]         waddr;
		logic signed [DATA_W-1:0] wdata;
		logic                     re;
		logic [IDX_W-1:0]         raddr;
	} ram_req_t;

	// One result: data comes from the ring read port when from_ram is set, else zero.
	typedef struct packed {
		logic    vld;
		logic    from_ram;
		status_t status;
		logic    last;
	} res_t;

	function automatic logic [IDX_W-1:0] next_pos(input logic [IDX_W-1:0] p);
		return (p == IDX_LAST) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [IDX_W-1:0] prev_pos(input logic [IDX_W-1:0] p);
		return (p == '0) ? IDX_LAST : p - 1'b1;
	endfunction

endpackage

// ----- sv/circular_deque.sv -----
// Double-ended queue of DEPTH 32-bit words held in one ring RAM. An item is
// taken when start is high and busy is low. Push and pop items give a single
// result with strobe in the next cycle; busy stays low, so such items can
// follow every cycle. A list item walks the ring through the RAM's one read
// port, one stored word per cycle: busy is high while the list runs and each
// result follows in the cycle after its read, the final one marked by last.
// Pushes into a full ring and pops or lists on an empty ring give one result
// with an error status and zero data; undefined ops give no result. The
// receiver cannot stall: each result is on the ports for exactly one cycle.
// The ring needs no clearing after reset.
module circular_deque
	import cdq_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [2:0]               op,
	input  logic signed [DATA_W-1:0] value,
	output logic                     strobe,
	output logic signed [DATA_W-1:0] data,
	output logic [1:0]               status,
	output logic                     last
);

	ram_req_t                 ram_req;
	res_t                     res_s1;
	logic signed [DATA_W-1:0] rdata;

	cdq_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.op      (op),
		.value   (value),
		.busy    (busy),
		.ram_req (ram_req),
		.res_s1  (res_s1)
	);

	cdq_ram #(
		.WIDTH (DATA_W),
		.DEPTH (DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.re    (ram_req.re),
		.raddr (ram_req.raddr),
		.rdata (rdata)
	);

	assign strobe = res_s1.vld;
	assign data   = (res_s1.vld && res_s1.from_ram) ? rdata : '0;
	assign status = res_s1.status;
	assign last   = res_s1.last;

endmodule

// ----- sv/cdq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module cdq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                              clk,
	input  logic                              we,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
	input  logic [WIDTH-1:0]                  wdata,
	input  logic                              re,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
	output logic [WIDTH-1:0]                  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- sv/cdq_ctrl.sv -----
// Deque control: pointers, occupancy, list sequencer and result staging.
module cdq_ctrl
	import cdq_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [2:0]               op,
	input  logic signed [DATA_W-1:0] value,
	output logic                     busy,
	output ram_req_t                 ram_req,
	output res_t                     res_s1
);

	state_t           state_q, state_n;
	logic [IDX_W-1:0] head_q, head_n;
	logic [IDX_W-1:0] tail_q, tail_n;
	logic [CNT_W-1:0] occ_q, occ_n;
	logic [IDX_W-1:0] pos_q, pos_n;
	logic [CNT_W-1:0] remain_q, remain_n;
	res_t             res_n;
	logic             accept;
	logic             is_empty;
	logic             is_full;

	assign busy     = (state_q != S_IDLE);
	assign accept   = start && (state_q == S_IDLE);
	assign is_empty = (occ_q == '0);
	assign is_full  = (occ_q == OCC_FULL);

	always_comb begin
		state_n  = state_q;
		head_n   = head_q;
		tail_n   = tail_q;
		occ_n    = occ_q;
		pos_n    = pos_q;
		remain_n = remain_q;
		res_n    = '{vld: 1'b0, from_ram: 1'b0, status: ST_OK, last: 1'b0};
		ram_req  = '{we: 1'b0, waddr: '0, wdata: value, re: 1'b0, raddr: '0};

		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (op_t'(op))
						OP_PUSH_FRONT, OP_PUSH_REAR: begin
							res_n.vld  = 1'b1;
							res_n.last = 1'b1;
							if (is_full) begin
								res_n.status = ST_FULL;
							end else begin
								ram_req.we = 1'b1;
								occ_n      = occ_q + 1'b1;
								if (is_empty) begin
									head_n        = '0;
									tail_n        = '0;
									ram_req.waddr = '0;
								end else if (op_t'(op) == OP_PUSH_FRONT) begin
									head_n        = prev_pos(head_q);
									ram_req.waddr = head_n;
								end else begin
									tail_n        = next_pos(tail_q);
									ram_req.waddr = tail_n;
								end
							end
						end
						OP_POP_FRONT, OP_POP_REAR: begin
							res_n.vld  = 1'b1;
							res_n.last = 1'b1;
							if (is_empty) begin
								res_n.status = ST_EMPTY;
							end else begin
								ram_req.re     = 1'b1;
								res_n.from_ram = 1'b1;
								occ_n          = occ_q - 1'b1;
								if (op_t'(op) == OP_POP_FRONT) begin
									ram_req.raddr = head_q;
									head_n        = next_pos(head_q);
								end else begin
									ram_req.raddr = tail_q;
									tail_n        = prev_pos(tail_q);
								end
								// removing the only word rewinds both ends
								if (occ_q == CNT_W'(1)) begin
									head_n = '0;
									tail_n = '0;
								end
							end
						end
						OP_LIST: begin
							if (is_empty) begin
								res_n.vld    = 1'b1;
								res_n.last   = 1'b1;
								res_n.status = ST_EMPTY;
							end else begin
								state_n  = S_LIST;
								pos_n    = head_q;
								remain_n = occ_q;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_LIST: begin
				ram_req.re     = 1'b1;
				ram_req.raddr  = pos_q;
				pos_n          = next_pos(pos_q);
				remain_n       = remain_q - 1'b1;
				res_n.vld      = 1'b1;
				res_n.from_ram = 1'b1;
				res_n.last     = (remain_q == CNT_W'(1));
				if (remain_q == CNT_W'(1)) begin
					state_n = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			head_q   <= '0;
			tail_q   <= '0;
			occ_q    <= '0;
			pos_q    <= '0;
			remain_q <= '0;
			res_s1   <= '{vld: 1'b0, from_ram: 1'b0, status: ST_OK, last: 1'b0};
		end else begin
			state_q  <= state_n;
			head_q   <= head_n;
			tail_q   <= tail_n;
			occ_q    <= occ_n;
			pos_q    <= pos_n;
			remain_q <= remain_n;
			res_s1   <= res_n;
		end
	end

endmodule

// ----- sv/cdq_checker.sv -----
// Port-level checks for the circular deque, bound to the top level.
`include "circular_deque_macros.svh"

module cdq_checker
	import cdq_pkg::*;
(
	input logic                     clk,
	input logic                     arst_n,
	input logic                     start,
	input logic                     busy,
	input logic [2:0]               op,
	input logic                     strobe,
	input logic signed [DATA_W-1:0] data,
	input logic [1:0]               status,
	input logic                     last
);

	logic item_taken;
	logic pushpop_op;
	logic known_op;
	logic status_known;

	assign item_taken   = start && !busy;
	assign pushpop_op   = (op == OP_PUSH_FRONT) || (op == OP_PUSH_REAR) ||
		(op == OP_POP_FRONT) || (op == OP_POP_REAR);
	assign known_op     = pushpop_op || (op == OP_LIST);
	assign status_known = (status == ST_OK) || (status == ST_FULL) || (status == ST_EMPTY);

	`CDQ_ASSERT_IMPLY(a_status_code, strobe, status_known)
	`CDQ_ASSERT_IMPLY(a_err_is_final, strobe && status != ST_OK, last && data == '0)
	`CDQ_ASSERT_NEXT(a_pushpop_result, item_taken && pushpop_op, strobe && last && !busy)
	`CDQ_ASSERT_NEXT(a_list_emits, busy, strobe)
	`CDQ_ASSERT_NEXT(a_bad_op_quiet, item_taken && !known_op, !strobe && !busy)

endmodule

bind circular_deque cdq_checker u_cdq_checker (.*);
